>>> rtl/go_back_n_sender_window_defines.svh
// Assertion macros shared by the go-back-N sender window RTL.
// Each macro takes a label, the clock, the synchronous reset and a property
// or condition; checks are disabled while reset is high.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property at every rising clock edge outside reset.
`define GBN_ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("gbn assertion failed");

// Check that a condition never holds outside reset.
`define GBN_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("gbn forbidden condition seen");

`else

`define GBN_ASSERT_PROP(lbl, clk, rst, prop)
`define GBN_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

>>> rtl/gbn_pkg.sv
package gbn_pkg;

  localparam int unsigned SeqW         = 32;
  localparam int unsigned WinW         = 7;
  localparam int unsigned RetryW       = 8;
  localparam int unsigned DefMaxWindow = 64;

  localparam logic [WinW-1:0]   WindowReset = 7'd8;
  localparam logic [RetryW-1:0] RetryReset  = 8'd9;
  localparam logic [RetryW-1:0] RetrySat    = 8'hFF;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_RETRY_LIMIT = 1'b1
  } cfg_reg_t;

  // Request kinds carried on the input side
  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_GRANTED     = 3'd0,
    ST_FULL        = 3'd1,
    ST_ACK_APPLIED = 3'd2,
    ST_ACK_IGNORED = 3'd3,
    ST_COMPLETE    = 3'd4,
    ST_RESEND      = 3'd5,
    ST_NONE_OUT    = 3'd6,
    ST_INACTIVE    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    MODE_ACTIVE   = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_FAILED   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUTST,
    S_CMP_WIN,
    S_INC_NEXT,
    S_ACK_OFF,
    S_ACK_CMP,
    S_ACK_SET,
    S_TO_BASE,
    S_TO_LIMIT,
    S_RESEND,
    S_EMIT
  } fsm_t;

  // Operation for the shared adder/subtractor
  typedef struct packed {
    logic [SeqW-1:0] a;
    logic [SeqW-1:0] b;
    logic            sub;
  } alu_op_t;

  typedef struct packed {
    logic [SeqW-1:0] sum;
    logic            carry;
  } alu_res_t;

  // One result item
  typedef struct packed {
    status_t         status;
    logic [SeqW-1:0] seq;
    logic [SeqW-1:0] base;
    logic [SeqW-1:0] next;
    logic            failed;
    logic            last;
  } result_t;

endpackage

>>> rtl/gbn_alu.sv
module gbn_alu (
  input  gbn_pkg::alu_op_t  op,
  output gbn_pkg::alu_res_t res
);
  import gbn_pkg::*;

  logic [SeqW:0] total;

  // Add, or subtract as a + ~b + 1; carry out set means no borrow
  assign total = {1'b0, op.a} + {1'b0, op.b ^ {SeqW{op.sub}}} + {{SeqW{1'b0}}, op.sub};

  assign res.sum   = total[SeqW-1:0];
  assign res.carry = total[SeqW];

endmodule

>>> rtl/gbn_ctrl.sv
`include "go_back_n_sender_window_defines.svh"

module gbn_ctrl #(
  parameter int unsigned MAX_WINDOW = gbn_pkg::DefMaxWindow
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req,
  input  logic [gbn_pkg::SeqW-1:0]    in_ack,
  input  logic                        in_last,
  input  logic [gbn_pkg::WinW-1:0]    window_size,
  input  logic [gbn_pkg::RetryW-1:0]  retry_limit,
  output gbn_pkg::alu_op_t            alu_op,
  input  gbn_pkg::alu_res_t           alu_res,
  input  logic                        out_free,
  output logic                        res_load,
  output gbn_pkg::result_t            res
);
  import gbn_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);

  fsm_t state, state_next;

  req_t              req_q;
  logic [SeqW-1:0]   ack_q;
  logic              last_q;
  logic [SeqW-1:0]   base_seq;
  logic [SeqW-1:0]   next_seq;
  logic [RetryW-1:0] retry_count;
  logic [SeqW-1:0]   last_to_base;
  mode_t             mode;
  logic [SeqW-1:0]   outst;
  logic [SeqW-1:0]   ack_off;
  logic [CntW-1:0]   run_len;
  logic [CntW-1:0]   idx;
  logic [CntW-1:0]   idx_inc;
  status_t           res_status;
  logic [SeqW-1:0]   res_seq;
  logic              res_failed;
  logic [WinW-1:0]   win_eff;
  logic [CntW-1:0]   run_clamp;

  // Clamp the window register into 1..MAX_WINDOW
  always_comb begin
    if (window_size == '0) begin
      win_eff = WinW'(1);
    end else if (window_size > WinW'(MAX_WINDOW)) begin
      win_eff = WinW'(MAX_WINDOW);
    end else begin
      win_eff = window_size;
    end
  end

  // Resend run length: outstanding count capped at MAX_WINDOW
  assign run_clamp = (outst > SeqW'(MAX_WINDOW)) ? CntW'(MAX_WINDOW) : outst[CntW-1:0];
  assign idx_inc   = idx + CntW'(1);

  assign in_ready = (state == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, shared unit operands and result load
  always_comb begin
    state_next = state;
    alu_op.a   = next_seq;
    alu_op.b   = base_seq;
    alu_op.sub = 1'b1;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (req_t'(in_req) != REQ_NONE)) begin
          state_next = S_OUTST;
        end
      end
      S_OUTST: begin
        if (mode != MODE_ACTIVE) begin
          state_next = S_EMIT;
        end else begin
          case (req_q)
            REQ_SEND:    state_next = S_CMP_WIN;
            REQ_ACK:     state_next = last_q ? S_EMIT : S_ACK_OFF;
            default:     state_next = S_TO_BASE;
          endcase
        end
      end
      S_CMP_WIN: begin
        alu_op.a   = outst;
        alu_op.b   = SeqW'(win_eff);
        state_next = alu_res.carry ? S_EMIT : S_INC_NEXT;
      end
      S_INC_NEXT: begin
        alu_op.a   = next_seq;
        alu_op.b   = SeqW'(1);
        alu_op.sub = 1'b0;
        state_next = S_EMIT;
      end
      S_ACK_OFF: begin
        alu_op.a   = ack_q;
        alu_op.b   = base_seq;
        state_next = S_ACK_CMP;
      end
      S_ACK_CMP: begin
        alu_op.a   = ack_off;
        alu_op.b   = outst;
        state_next = alu_res.carry ? S_EMIT : S_ACK_SET;
      end
      S_ACK_SET: begin
        alu_op.a   = ack_q;
        alu_op.b   = SeqW'(1);
        alu_op.sub = 1'b0;
        state_next = S_EMIT;
      end
      S_TO_BASE: begin
        alu_op.a = base_seq;
        alu_op.b = last_to_base;
        if (outst == '0) begin
          state_next = S_EMIT;
        end else if (alu_res.sum == '0) begin
          state_next = S_TO_LIMIT;
        end else begin
          state_next = S_RESEND;
        end
      end
      S_TO_LIMIT: begin
        alu_op.a   = SeqW'(retry_count);
        alu_op.b   = SeqW'(retry_limit);
        state_next = S_RESEND;
      end
      S_RESEND: begin
        alu_op.a   = base_seq;
        alu_op.b   = SeqW'(idx);
        alu_op.sub = 1'b0;
        if (out_free) begin
          res_load = 1'b1;
          if (idx_inc == run_len) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq     <= '0;
      next_seq     <= '0;
      retry_count  <= '0;
      last_to_base <= '0;
      mode         <= MODE_ACTIVE;
      idx          <= '0;
      run_len      <= '0;
    end else begin
      unique case (state)
        S_OUTST: begin
          if ((mode == MODE_ACTIVE) && (req_q == REQ_ACK) && last_q) begin
            base_seq <= next_seq;
            mode     <= MODE_COMPLETE;
          end
        end
        S_INC_NEXT: begin
          next_seq <= alu_res.sum;
        end
        S_ACK_SET: begin
          base_seq <= alu_res.sum;
        end
        S_TO_BASE: begin
          if (outst != '0) begin
            last_to_base <= base_seq;
            run_len      <= run_clamp;
            idx          <= '0;
            if (alu_res.sum == '0) begin
              if (retry_count != RetrySat) begin
                retry_count <= retry_count + RetryW'(1);
              end
            end else begin
              retry_count <= '0;
            end
          end
        end
        S_TO_LIMIT: begin
          if (alu_res.carry) begin
            mode <= MODE_FAILED;
          end
        end
        S_RESEND: begin
          if (out_free) begin
            idx <= idx_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Latched request and staged result fields
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q  <= req_t'(in_req);
      ack_q  <= in_ack;
      last_q <= in_last;
    end
    unique case (state)
      S_OUTST: begin
        outst <= alu_res.sum;
        if (mode != MODE_ACTIVE) begin
          res_status <= ST_INACTIVE;
          res_seq    <= '0;
          res_failed <= (mode == MODE_FAILED);
        end else begin
          res_status <= ST_COMPLETE;
          res_seq    <= ack_q;
          res_failed <= 1'b0;
        end
      end
      S_CMP_WIN: begin
        res_seq    <= next_seq;
        res_status <= alu_res.carry ? ST_FULL : ST_GRANTED;
      end
      S_ACK_OFF: begin
        ack_off <= alu_res.sum;
      end
      S_ACK_CMP: begin
        res_seq    <= ack_q;
        res_status <= alu_res.carry ? ST_ACK_IGNORED : ST_ACK_APPLIED;
      end
      S_TO_BASE: begin
        res_status <= ST_NONE_OUT;
        res_seq    <= base_seq;
        res_failed <= 1'b0;
      end
      S_TO_LIMIT: begin
        res_failed <= alu_res.carry;
      end
      default: begin
      end
    endcase
  end

  // Result item: resend runs take the sequence number from the shared unit
  always_comb begin
    res.status = (state == S_RESEND) ? ST_RESEND : res_status;
    res.seq    = (state == S_RESEND) ? alu_res.sum : res_seq;
    res.base   = base_seq;
    res.next   = next_seq;
    res.failed = res_failed;
    res.last   = (state == S_RESEND) ? (idx_inc == run_len) : 1'b1;
  end

  `GBN_ASSERT_PROP(a_idx_bound, clk, rst, (state == S_RESEND) |-> (idx < run_len))
  `GBN_ASSERT_PROP(a_run_nonzero, clk, rst, (state == S_RESEND) |-> (run_len != '0))
  `GBN_ASSERT_PROP(a_mode_sticky, clk, rst, (mode != MODE_ACTIVE) |=> (mode != MODE_ACTIVE))
  `GBN_ASSERT_PROP(a_load_free, clk, rst, res_load |-> out_free)

endmodule

>>> rtl/go_back_n_sender_window.sv
// Channel  Dir  Handshake         Payload
// s_*      in   s_tvalid/tready   tdata: ack_seq; tuser: req_type; tlast: ack_last
// m_*      out  m_tvalid/tready   tdata: seq, base_out, next_out; tuser: status, failed;
//                                 tlast: last_of_run
// cfg_*    in   cfg_valid/ready   cfg_index: register; cfg_data: value
//
// One shared 32-bit adder/subtractor is stepped by a sequencer; the input is
// not ready until the current item has handed its last result to the output register.
// Send checks the window and advances next unless full; ack checks its offset and, if in
// range, moves base (last completes); timeout emits if none is outstanding, else
// resends up to MAX_WINDOW numbers; reserved requests are dropped; stalls hold results.
// Reset is synchronous and clears the window state and output valid; config any cycle.
module go_back_n_sender_window #(
  parameter int unsigned MAX_WINDOW = gbn_pkg::DefMaxWindow
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] ack_seq
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] seq, [63:32] base_out, [95:64] next_out
  output logic [3:0]  m_tuser,   // [2:0] status, [3] failed
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import gbn_pkg::*;

  logic [WinW-1:0]   window_size;
  logic [RetryW-1:0] retry_limit;
  alu_op_t           alu_op;
  alu_res_t          alu_res;
  logic              out_free;
  logic              res_load;
  result_t           res;
  result_t           out_q;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WindowReset;
      retry_limit <= RetryReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WINDOW_SIZE: window_size <= cfg_data[WinW-1:0];
        CFG_RETRY_LIMIT: retry_limit <= cfg_data[RetryW-1:0];
        default: begin
        end
      endcase
    end
  end

  gbn_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  gbn_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_req      (s_tuser),
    .in_ack      (s_tdata),
    .in_last     (s_tlast),
    .window_size (window_size),
    .retry_limit (retry_limit),
    .alu_op      (alu_op),
    .alu_res     (alu_res),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  // Output register: load when empty or being drained
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_tdata = {out_q.next, out_q.base, out_q.seq};
  assign m_tuser = {out_q.failed, out_q.status};
  assign m_tlast = out_q.last;

endmodule
